// ----- rtl/histogram_median_binarizer_defines.svh -----
// Assertion macros shared by the histogram median binarizer RTL.
`ifndef HISTOGRAM_MEDIAN_BINARIZER_DEFINES_SVH
`define HISTOGRAM_MEDIAN_BINARIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define HMB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("histogram median binarizer assertion failed");
`define HMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("histogram median binarizer assertion failed");
`else
`define HMB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HMB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/hmb_pkg.sv -----
// Types and constants of the histogram median binarizer.
`timescale 1ns / 1ps
package hmb_pkg;
    localparam int LEVELS  = 256;
    localparam int LEVEL_W = 8;
    localparam logic [LEVEL_W-1:0] WHITE = 8'hFF;
    localparam logic [LEVEL_W-1:0] BLACK = 8'h00;
    localparam logic [LEVEL_W-1:0] LAST_LEVEL = 8'hFF;

    typedef enum logic [1:0] {
        REQ_GATHER   = 2'd0,
        REQ_FINISH   = 2'd1,
        REQ_BINARIZE = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_REPORT
    } scan_state_t;

    typedef struct packed {
        logic               idle;
        logic               busy;
        logic               wr_en;
        logic [LEVEL_W-1:0] addr;
        logic               report;
        logic [LEVEL_W-1:0] median;
    } scan_ctrl_t;
endpackage

// ----- rtl/histogram_median_binarizer.sv -----
// Top level of the histogram median binarizer.
// Gather and binarize transactions are taken one per cycle while the sequencer is idle
// and the output register is free; a binarize result appears in the output register in
// the cycle after its transaction. A finish transaction stalls the input while every bin
// is read and cleared through the memory port, the last bin is accumulated and the median
// is reported. After reset the input stays stalled while the bins are cleared.
`timescale 1ns / 1ps
`include "histogram_median_binarizer_defines.svh"
module histogram_median_binarizer #(
    parameter int MAX_FRAME_PIXELS = 262144
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] pixel
    input  logic [1:0] s_tuser,   // [1:0] req_type
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] value
    output logic [0:0] m_tuser    // [0] is_median
);
    localparam int BIN_W = $clog2(MAX_FRAME_PIXELS + 1);
    localparam logic [BIN_W-1:0] MAX_TOTAL = BIN_W'(MAX_FRAME_PIXELS);

    hmb_pkg::req_t               req;
    hmb_pkg::scan_ctrl_t         scan_ctrl;
    logic                        s_accept;
    logic                        out_free;
    logic                        gather_take;
    logic                        finish_take;
    logic                        bin_take;
    logic                        g_we;
    logic [hmb_pkg::LEVEL_W-1:0] g_addr;
    logic [BIN_W-1:0]            g_data;
    logic [BIN_W-1:0]            g_total;
    logic [BIN_W-1:0]            rd_data;
    logic                        mem_we;
    logic [hmb_pkg::LEVEL_W-1:0] mem_waddr;
    logic [BIN_W-1:0]            mem_wdata;
    logic [hmb_pkg::LEVEL_W-1:0] mem_raddr;
    logic [hmb_pkg::LEVEL_W-1:0] median_level_reg;
    logic                        m_valid_reg;
    logic [hmb_pkg::LEVEL_W-1:0] m_value_reg;
    logic                        m_is_median_reg;

    assign req      = hmb_pkg::req_t'(s_tuser);
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = scan_ctrl.idle && out_free;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        gather_take = 1'b0;
        finish_take = 1'b0;
        bin_take    = 1'b0;
        if (s_accept) begin
            unique case (req)
                hmb_pkg::REQ_GATHER:   gather_take = 1'b1;
                hmb_pkg::REQ_FINISH:   finish_take = 1'b1;
                hmb_pkg::REQ_BINARIZE: bin_take    = 1'b1;
                default: ;
            endcase
        end
    end

    assign mem_raddr = scan_ctrl.busy ? scan_ctrl.addr : s_tdata;
    assign mem_we    = scan_ctrl.wr_en || g_we;
    assign mem_waddr = scan_ctrl.wr_en ? scan_ctrl.addr : g_addr;
    assign mem_wdata = scan_ctrl.wr_en ? '0 : g_data;

    hmb_hist_mem #(
        .DATA_W (BIN_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (rd_data)
    );

    hmb_gather #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_gather (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (gather_take),
        .pixel       (s_tdata),
        .clear_total (finish_take),
        .rd_data     (rd_data),
        .wr_en       (g_we),
        .wr_addr     (g_addr),
        .wr_data     (g_data),
        .total       (g_total)
    );

    hmb_scan #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (finish_take),
        .total    (g_total),
        .out_free (out_free),
        .rd_data  (rd_data),
        .ctrl     (scan_ctrl)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            median_level_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (scan_ctrl.report) begin
                median_level_reg <= scan_ctrl.median;
            end
            if (scan_ctrl.report || bin_take) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_ctrl.report) begin
            m_value_reg     <= scan_ctrl.median;
            m_is_median_reg <= 1'b1;
        end else if (bin_take) begin
            m_value_reg     <= (s_tdata < median_level_reg) ? hmb_pkg::BLACK : hmb_pkg::WHITE;
            m_is_median_reg <= 1'b0;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_value_reg;
    assign m_tuser[0] = m_is_median_reg;

    `HMB_ASSERT_NEXT(a_finish_starts_scan, aclk, aresetn, finish_take, scan_ctrl.busy)
    `HMB_ASSERT_NEXT(a_gather_counts, aclk, aresetn, gather_take && (g_total < MAX_TOTAL), g_total == $past(g_total) + BIN_W'(1))
    `HMB_ASSERT_SAME(a_single_writer, aclk, aresetn, 1'b1, !(scan_ctrl.wr_en && g_we))
endmodule

// ----- rtl/hmb_hist_mem.sv -----
// Histogram bin memory with one write port and one registered read port.
`timescale 1ns / 1ps
module hmb_hist_mem #(
    parameter int DATA_W = 19
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [hmb_pkg::LEVEL_W-1:0] wr_addr,
    input  logic [DATA_W-1:0]          wr_data,
    input  logic [hmb_pkg::LEVEL_W-1:0] rd_addr,
    output logic [DATA_W-1:0]          rd_data
);
    logic [DATA_W-1:0] mem_reg [hmb_pkg::LEVELS];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ----- rtl/hmb_gather.sv -----
// Bin increment pipeline with write-back forwarding and the pixel total.
`timescale 1ns / 1ps
module hmb_gather #(
    parameter int MAX_FRAME_PIXELS = 262144
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      take,
    input  logic [hmb_pkg::LEVEL_W-1:0]               pixel,
    input  logic                                      clear_total,
    input  logic [$clog2(MAX_FRAME_PIXELS + 1)-1:0]   rd_data,
    output logic                                      wr_en,
    output logic [hmb_pkg::LEVEL_W-1:0]               wr_addr,
    output logic [$clog2(MAX_FRAME_PIXELS + 1)-1:0]   wr_data,
    output logic [$clog2(MAX_FRAME_PIXELS + 1)-1:0]   total
);
    localparam int BIN_W = $clog2(MAX_FRAME_PIXELS + 1);
    localparam logic [BIN_W-1:0] MAX_TOTAL = BIN_W'(MAX_FRAME_PIXELS);

    logic [BIN_W-1:0]            total_reg, total_next;
    logic                        s1_valid_reg;
    logic [hmb_pkg::LEVEL_W-1:0] s1_addr_reg;
    logic                        fwd_valid_reg;
    logic [hmb_pkg::LEVEL_W-1:0] fwd_addr_reg;
    logic [BIN_W-1:0]            fwd_data_reg;
    logic                        room;
    logic [BIN_W-1:0]            base;
    logic [BIN_W-1:0]            bin_next;

    assign room = (total_reg < MAX_TOTAL);

    always_comb begin
        priority if (clear_total) begin
            total_next = '0;
        end else if (take && room) begin
            total_next = total_reg + BIN_W'(1);
        end else begin
            total_next = total_reg;
        end
    end

    // The bin written in the previous cycle is not yet visible at the read port.
    assign base = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rd_data;
    assign bin_next = base + BIN_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            total_reg     <= total_next;
            s1_valid_reg  <= take && room;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_addr_reg  <= pixel;
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= bin_next;
    end

    assign wr_en   = s1_valid_reg;
    assign wr_addr = s1_addr_reg;
    assign wr_data = bin_next;
    assign total   = total_reg;
endmodule

// ----- rtl/hmb_scan.sv -----
// Sequencer for the clearing pass after reset and the median scan over the bins.
`timescale 1ns / 1ps
module hmb_scan #(
    parameter int MAX_FRAME_PIXELS = 262144
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    start,
    input  logic [$clog2(MAX_FRAME_PIXELS + 1)-1:0] total,
    input  logic                                    out_free,
    input  logic [$clog2(MAX_FRAME_PIXELS + 1)-1:0] rd_data,
    output hmb_pkg::scan_ctrl_t                     ctrl
);
    localparam int BIN_W = $clog2(MAX_FRAME_PIXELS + 1);

    hmb_pkg::scan_state_t        state_reg, state_next;
    logic [hmb_pkg::LEVEL_W-1:0] cnt_reg, cnt_next;
    logic                        rd_valid_reg;
    logic [hmb_pkg::LEVEL_W-1:0] rd_idx_reg;
    logic [BIN_W-1:0]            run_reg;
    logic [BIN_W-1:0]            half_reg;
    logic                        found_reg;
    logic [hmb_pkg::LEVEL_W-1:0] median_reg;
    logic [BIN_W-1:0]            sum;

    assign sum = run_reg + rd_data;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            hmb_pkg::ST_CLEAR: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == hmb_pkg::LAST_LEVEL) begin
                    state_next = hmb_pkg::ST_IDLE;
                end
            end
            hmb_pkg::ST_IDLE: begin
                cnt_next = '0;
                if (start) begin
                    state_next = hmb_pkg::ST_SCAN;
                end
            end
            hmb_pkg::ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == hmb_pkg::LAST_LEVEL) begin
                    state_next = hmb_pkg::ST_TAIL;
                end
            end
            hmb_pkg::ST_TAIL: begin
                state_next = hmb_pkg::ST_REPORT;
            end
            hmb_pkg::ST_REPORT: begin
                if (out_free) begin
                    state_next = hmb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hmb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl.idle   = (state_reg == hmb_pkg::ST_IDLE);
        ctrl.busy   = (state_reg == hmb_pkg::ST_CLEAR) || (state_reg == hmb_pkg::ST_SCAN);
        ctrl.wr_en  = ctrl.busy;
        ctrl.addr   = cnt_reg;
        ctrl.report = (state_reg == hmb_pkg::ST_REPORT) && out_free;
        ctrl.median = median_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hmb_pkg::ST_CLEAR;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            median_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= (state_reg == hmb_pkg::ST_SCAN);
            if (start) begin
                found_reg  <= 1'b0;
                median_reg <= '0;
            end else if (rd_valid_reg && !found_reg && (sum > half_reg)) begin
                found_reg  <= 1'b1;
                median_reg <= rd_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= cnt_reg;
        if (start) begin
            run_reg  <= '0;
            half_reg <= total >> 1;
        end else if (rd_valid_reg) begin
            run_reg <= sum;
        end
    end
endmodule

// ----- bench/tb_histogram_median_binarizer.sv -----
`timescale 1ns / 1ps
// Self-checking stream testbench for the histogram median binarizer, with a built-in predictor.
module tb_histogram_median_binarizer;
    localparam int unsigned FRAME_LIMIT = 262144;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned SINK_HOLD   = 400;
    localparam int unsigned SETTLE      = 300;
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;

    typedef struct packed {
        logic [7:0] value;
        logic       is_median;
    } result_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] pixel
    logic [1:0] s_tuser;   // [1:0] req_type
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] value
    logic [0:0] m_tuser;   // [0] is_median

    result_t     pending_results[$];
    int unsigned level_count[hmb_pkg::LEVELS];
    int unsigned frame_total     = 0;
    logic [7:0]  expected_median = 8'd0;
    int unsigned mismatch_count  = 0;
    int unsigned cycle_count     = 0;
    int unsigned requests_sent   = 0;
    bit          src_steady      = 1'b0;
    bit          sink_steady     = 1'b0;
    bit          sink_hold       = 1'b0;

    histogram_median_binarizer #(
        .MAX_FRAME_PIXELS(FRAME_LIMIT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        foreach (level_count[i]) level_count[i] = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void predict_response(input logic [1:0] kind, input logic [7:0] px);
        int unsigned half;
        int unsigned running;
        bit          found;
        result_t     res;
        case (kind)
            hmb_pkg::REQ_GATHER: begin
                if (frame_total < FRAME_LIMIT) begin
                    level_count[px]++;
                    frame_total++;
                end
            end
            hmb_pkg::REQ_FINISH: begin
                half = frame_total / 2;
                running = 0;
                found = 1'b0;
                expected_median = hmb_pkg::BLACK;
                for (int lvl = 0; lvl < hmb_pkg::LEVELS; lvl++) begin
                    if (!found) begin
                        running += level_count[lvl];
                        if (running > half) begin
                            expected_median = 8'(lvl);
                            found = 1'b1;
                        end
                    end
                end
                foreach (level_count[i]) level_count[i] = 0;
                frame_total = 0;
                res.value = expected_median;
                res.is_median = 1'b1;
                pending_results.push_back(res);
            end
            hmb_pkg::REQ_BINARIZE: begin
                res.value = (px < expected_median) ? hmb_pkg::BLACK : hmb_pkg::WHITE;
                res.is_median = 1'b0;
                pending_results.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic int unsigned pick_gap(input bit steady);
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [7:0] clamp_level(input int v);
        if (v < 0) return hmb_pkg::BLACK;
        if (v > 255) return hmb_pkg::WHITE;
        return 8'(v);
    endfunction

    function automatic logic [7:0] frame_pixel(input int unsigned style, input int centre);
        case (style)
            0: return 8'($urandom);
            1: return clamp_level(centre + int'($urandom_range(0, 6)) - 3);
            2: return $urandom_range(0, 1) ? 8'(centre) : 8'(255 - centre);
            default: return $urandom_range(0, 1) ? hmb_pkg::BLACK : hmb_pkg::WHITE;
        endcase
    endfunction

    // Called just after a rising edge; leaves just after the accepting edge.
    task automatic send_request(input logic [1:0] kind, input logic [7:0] px,
                                input int unsigned gap);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        predict_response(kind, px);
        if (kind != REQ_UNUSED) requests_sent++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic finish_phase();
        stop_sending();
        wait_drained();
    endtask

    task automatic test_reset_threshold();
        send_request(hmb_pkg::REQ_BINARIZE, hmb_pkg::BLACK, 0);
        send_request(REQ_UNUSED, 8'hAA, 1);
        send_request(hmb_pkg::REQ_BINARIZE, hmb_pkg::WHITE, 0);
        send_request(hmb_pkg::REQ_BINARIZE, 8'h55, 2);
        finish_phase();
    endtask

    task automatic test_empty_frame();
        send_request(hmb_pkg::REQ_FINISH, 8'h00, 0);
        send_request(hmb_pkg::REQ_BINARIZE, hmb_pkg::BLACK, 0);
        finish_phase();
    endtask

    task automatic test_directed_levels();
        send_request(hmb_pkg::REQ_GATHER, hmb_pkg::BLACK, 0);
        send_request(hmb_pkg::REQ_GATHER, hmb_pkg::WHITE, 0);
        send_request(REQ_UNUSED, hmb_pkg::BLACK, 0);
        send_request(hmb_pkg::REQ_GATHER, hmb_pkg::WHITE, 1);
        send_request(hmb_pkg::REQ_FINISH, 8'hFF, 0);
        send_request(hmb_pkg::REQ_BINARIZE, 8'd254, 0);
        send_request(hmb_pkg::REQ_BINARIZE, hmb_pkg::WHITE, 0);
        send_request(hmb_pkg::REQ_GATHER, 8'd128, 3);
        send_request(hmb_pkg::REQ_FINISH, 8'h5A, 0);
        send_request(hmb_pkg::REQ_BINARIZE, 8'd127, 0);
        send_request(hmb_pkg::REQ_BINARIZE, 8'd128, 0);
        repeat (3) send_request(hmb_pkg::REQ_GATHER, hmb_pkg::BLACK, 0);
        send_request(hmb_pkg::REQ_FINISH, 8'hA5, 0);
        send_request(hmb_pkg::REQ_BINARIZE, hmb_pkg::BLACK, 0);
        finish_phase();
    endtask

    task automatic test_backpressure();
        src_steady = 1'b1;
        repeat (5) send_request(hmb_pkg::REQ_GATHER, 8'($urandom), 0);
        send_request(hmb_pkg::REQ_FINISH, 8'($urandom), 0);
        sink_hold = 1'b1;
        repeat (40) send_request(hmb_pkg::REQ_BINARIZE, 8'($urandom), 0);
        stop_sending();
        wait_drained();
        repeat (4) send_request(hmb_pkg::REQ_GATHER, 8'($urandom), 0);
        send_request(hmb_pkg::REQ_FINISH, 8'($urandom), 0);
        send_request(hmb_pkg::REQ_BINARIZE, 8'($urandom), 0);
        src_steady = 1'b0;
        finish_phase();
    endtask

    task automatic test_random_frames(input int unsigned target);
        int unsigned start;
        int unsigned n;
        int unsigned style;
        int          centre;
        int unsigned burst;
        start = requests_sent;
        while (requests_sent - start < target) begin
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 8) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
                style  = $urandom_range(0, 3);
                centre = $urandom_range(0, 255);
                for (int unsigned i = 0; i < n; i++) begin
                    if ($urandom_range(0, 29) == 0)
                        send_request(REQ_UNUSED, 8'($urandom), pick_gap(src_steady));
                    send_request(hmb_pkg::REQ_GATHER, frame_pixel(style, centre),
                                 pick_gap(src_steady));
                end
                send_request(hmb_pkg::REQ_FINISH, 8'($urandom), pick_gap(src_steady));
                burst = $urandom_range(1, 12);
                for (int unsigned i = 0; i < burst; i++) begin
                    send_request(hmb_pkg::REQ_BINARIZE,
                                 $urandom_range(0, 1) ? 8'($urandom) :
                                 clamp_level(int'(expected_median) +
                                             int'($urandom_range(0, 2)) - 1),
                                 pick_gap(src_steady));
                end
            end else begin
                repeat ($urandom_range(1, 8))
                    send_request(2'($urandom), 8'($urandom), pick_gap(src_steady));
            end
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        finish_phase();
    endtask

    initial begin
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (sink_hold) begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD) @(negedge aclk);
                sink_hold = 1'b0;
            end else if (sink_steady || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                @(negedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat (pick_gap(1'b0) + 1) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_checker
        result_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing outstanding", m_tdata, -1);
            end else begin
                due = pending_results.pop_front();
                if (m_tdata !== due.value)
                    report_mismatch("value", m_tdata, due.value);
                if (m_tuser[0] !== due.is_median)
                    report_mismatch("is_median", m_tuser[0], due.is_median);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("histogram_median_binarizer verification failed");
            $finish;
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tuser  = hmb_pkg::REQ_GATHER;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_threshold();
        test_empty_frame();
        test_directed_levels();
        test_backpressure();
        test_random_frames(560);

        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("histogram_median_binarizer verification clean");
        end else begin
            $display("histogram_median_binarizer verification failed");
        end
        $finish;
    end
endmodule
